>>> rtl/shortest_path_next_hop_defines.svh
// Assertion macros for the RTL that checks itself.
`ifndef SHORTEST_PATH_NEXT_HOP_DEFINES_SVH
`define SHORTEST_PATH_NEXT_HOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define SPNH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define SPNH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPNH_ASSERT_IMP(lbl, ante, cons, msg)
`define SPNH_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/spnh_pkg.sv
package spnh_pkg;

    // Command codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_ROUTE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Path cost width and the saturated / unreachable value
    localparam int          PATH_W   = 16;
    localparam logic [15:0] COST_INF = 16'hFFFF;

    // Routing table: bit 4 flags a bad route, bits 3..0 hold the hop
    localparam int         TABLE_DEPTH = 16;
    localparam int         HOP_W       = 4;
    localparam int         ENTRY_W     = 5;
    localparam logic [4:0] ENTRY_BAD   = 5'h10;

    typedef enum logic [8:0] {
        ST_CLEAR     = 9'b000000001,
        ST_IDLE      = 9'b000000010,
        ST_INIT      = 9'b000000100,
        ST_SCAN      = 9'b000001000,
        ST_PICK      = 9'b000010000,
        ST_RELAX     = 9'b000100000,
        ST_TRACE_RD  = 9'b001000000,
        ST_TRACE_CHK = 9'b010000000,
        ST_SPARE     = 9'b100000000
    } state_t;

endpackage

>>> rtl/shortest_path_next_hop.sv
// Ops 0 and 3 give no result; op 2 and op 1 toward an out-of-graph target or
// from an out-of-graph source give their result in the cycle after they are accepted.
// Op 1 search: init, then per visited node a scan, a pick and a relax pass over the
// single-read node memory, then a trace back along the predecessors to the source.
// Reset: clearing pass over all NODE_COUNT*NODE_COUNT link-cost words with busy high;
// routing table returns to identity. Results last one cycle; receiver cannot stall.
`include "shortest_path_next_hop_defines.svh"

module shortest_path_next_hop #(
    parameter int NODE_COUNT = 15,
    parameter int COST_BITS  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic [3:0] from_node,
    input  logic [3:0] to_node,
    input  logic [7:0] link_cost,
    input  logic [3:0] target_node,
    output logic       done,
    output logic       route_valid,
    output logic [3:0] next_hop
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int CNT_W  = $clog2(NODE_COUNT + 1);
    localparam int MAT_D  = NODE_COUNT * NODE_COUNT;
    localparam int MAT_AW = $clog2(MAT_D);
    localparam int PW     = spnh_pkg::PATH_W;
    localparam int NODE_W = PW + IDX_W + 1;

    spnh_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MAT_AW-1:0] clr_reg, clr_next;
    logic              pv_reg, pv_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic [PW-1:0]     best_reg, best_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [PW-1:0]     cur_cost_reg, cur_cost_next;
    logic [MAT_AW-1:0] row_base_reg, row_base_next;
    logic [IDX_W-1:0]  hop_reg, hop_next;
    logic [3:0]        tgt_reg, tgt_next;
    logic [IDX_W-1:0]  src_reg, src_next;
    logic [3:0]        own_address_reg;

    logic       done_reg, done_next;
    logic       route_valid_reg, route_valid_next;
    logic [3:0] next_hop_reg, next_hop_next;

    logic [spnh_pkg::ENTRY_W-1:0] route_table_reg [spnh_pkg::TABLE_DEPTH];
    logic                         tbl_we;
    logic [3:0]                   tbl_waddr;
    logic [spnh_pkg::ENTRY_W-1:0] tbl_wdata;

    logic                 mat_we;
    logic [MAT_AW-1:0]    mat_waddr, mat_raddr;
    logic [COST_BITS-1:0] mat_wdata, mat_rdata;

    logic              node_we;
    logic [IDX_W-1:0]  node_waddr, node_raddr;
    logic [NODE_W-1:0] node_wdata, node_rdata;

    logic              accept;
    logic              tgt_in, src_in, from_in, to_in;
    logic [PW-1:0]     rd_cost;
    logic [IDX_W-1:0]  rd_pred;
    logic              rd_vis;
    logic [PW:0]       sum;
    logic [PW-1:0]     new_cost;
    logic [IDX_W-1:0]  tgt_idx;
    logic              last_cnt;
    logic [spnh_pkg::ENTRY_W-1:0] fin_entry;
    logic              fin;

    assign busy        = (state_reg != spnh_pkg::ST_IDLE);
    assign done        = done_reg;
    assign route_valid = route_valid_reg;
    assign next_hop    = next_hop_reg;
    assign accept      = start && !busy;

    assign tgt_in  = 32'(target_node) < 32'(NODE_COUNT);
    assign src_in  = 32'(own_address_reg) < 32'(NODE_COUNT);
    assign from_in = 32'(from_node) < 32'(NODE_COUNT);
    assign to_in   = 32'(to_node) < 32'(NODE_COUNT);

    assign rd_cost  = node_rdata[PW-1:0];
    assign rd_pred  = node_rdata[PW+IDX_W-1:PW];
    assign rd_vis   = node_rdata[NODE_W-1];
    assign sum      = {1'b0, cur_cost_reg} + (PW+1)'(mat_rdata);
    assign new_cost = sum[PW] ? spnh_pkg::COST_INF : sum[PW-1:0];
    assign tgt_idx  = IDX_W'(tgt_reg);
    assign last_cnt = (cnt_reg == CNT_W'(NODE_COUNT));

    spnh_ram #(.WIDTH(COST_BITS), .DEPTH(MAT_D)) u_mat (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    spnh_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Sequencer: clear, init, scan for cheapest, relax its row, trace back
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        clr_next         = clr_reg;
        pv_next          = 1'b0;
        pidx_next        = pidx_reg;
        best_next        = best_reg;
        found_next       = found_reg;
        pick_next        = pick_reg;
        cur_next         = cur_reg;
        cur_cost_next    = cur_cost_reg;
        row_base_next    = row_base_reg;
        hop_next         = hop_reg;
        tgt_next         = tgt_reg;
        src_next         = src_reg;
        done_next        = 1'b0;
        route_valid_next = route_valid_reg;
        next_hop_next    = next_hop_reg;
        tbl_we           = 1'b0;
        tbl_waddr        = tgt_reg;
        tbl_wdata        = spnh_pkg::ENTRY_BAD;
        mat_we           = 1'b0;
        mat_waddr        = clr_reg;
        mat_wdata        = '0;
        mat_raddr        = row_base_reg + MAT_AW'(cnt_reg);
        node_we          = 1'b0;
        node_waddr       = pidx_reg;
        node_wdata       = node_rdata;
        node_raddr       = cnt_reg[IDX_W-1:0];
        fin              = 1'b0;
        fin_entry        = spnh_pkg::ENTRY_BAD;

        case (state_reg)
            spnh_pkg::ST_CLEAR:
            begin
                mat_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == MAT_AW'(MAT_D - 1))
                begin
                    state_next = spnh_pkg::ST_IDLE;
                end
            end
            spnh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    tgt_next = target_node;
                    src_next = IDX_W'(own_address_reg);
                    if (op == spnh_pkg::OP_WRITE)
                    begin
                        mat_we    = from_in && to_in;
                        mat_waddr = MAT_AW'(32'(from_node) * NODE_COUNT + 32'(to_node));
                        mat_wdata = COST_BITS'(link_cost);
                    end
                    else if (op == spnh_pkg::OP_READ
                             || (op == spnh_pkg::OP_ROUTE && !tgt_in))
                    begin
                        done_next        = 1'b1;
                        route_valid_next = !route_table_reg[target_node][4];
                        next_hop_next    = route_table_reg[target_node][4]
                                           ? 4'd0 : route_table_reg[target_node][3:0];
                    end
                    else if (op == spnh_pkg::OP_ROUTE)
                    begin
                        if (!src_in)
                        begin
                            tbl_waddr        = target_node;
                            tbl_we           = 1'b1;
                            done_next        = 1'b1;
                            route_valid_next = 1'b0;
                            next_hop_next    = 4'd0;
                        end
                        else
                        begin
                            cnt_next   = '0;
                            state_next = spnh_pkg::ST_INIT;
                        end
                    end
                end
            end
            spnh_pkg::ST_INIT:
            begin
                node_we    = 1'b1;
                node_waddr = cnt_reg[IDX_W-1:0];
                node_wdata = {1'b0, IDX_W'(0),
                              (cnt_reg[IDX_W-1:0] == src_reg) ? PW'(0) : spnh_pkg::COST_INF};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NODE_COUNT - 1))
                begin
                    cnt_next   = '0;
                    best_next  = spnh_pkg::COST_INF;
                    found_next = 1'b0;
                    state_next = spnh_pkg::ST_SCAN;
                end
            end
            spnh_pkg::ST_SCAN:
            begin
                // Issue one read a cycle, compare the beat read last cycle
                if (!last_cnt)
                begin
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pv_reg && !rd_vis && rd_cost < best_reg)
                begin
                    best_next  = rd_cost;
                    pick_next  = pidx_reg;
                    found_next = 1'b1;
                end
                if (last_cnt)
                begin
                    state_next = spnh_pkg::ST_PICK;
                end
            end
            spnh_pkg::ST_PICK:
            begin
                cnt_next = '0;
                if (!found_reg)
                begin
                    fin = 1'b1;
                end
                else if (pick_reg == tgt_idx)
                begin
                    if (tgt_idx == src_reg)
                    begin
                        fin       = 1'b1;
                        fin_entry = {1'b0, 4'(src_reg)};
                    end
                    else
                    begin
                        hop_next   = tgt_idx;
                        state_next = spnh_pkg::ST_TRACE_RD;
                    end
                end
                else
                begin
                    cur_next      = pick_reg;
                    cur_cost_next = best_reg;
                    row_base_next = MAT_AW'(32'(pick_reg) * NODE_COUNT);
                    state_next    = spnh_pkg::ST_RELAX;
                end
            end
            spnh_pkg::ST_RELAX:
            begin
                // Read the neighbor and its link together, write back from the registered read data
                if (!last_cnt)
                begin
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    if (mat_rdata != '0 && new_cost < rd_cost)
                    begin
                        node_we    = 1'b1;
                        node_wdata = {rd_vis, cur_reg, new_cost};
                    end
                    else if (pidx_reg == cur_reg)
                    begin
                        node_we    = 1'b1;
                        node_wdata = {1'b1, rd_pred, rd_cost};
                    end
                end
                if (last_cnt)
                begin
                    cnt_next   = '0;
                    best_next  = spnh_pkg::COST_INF;
                    found_next = 1'b0;
                    state_next = spnh_pkg::ST_SCAN;
                end
            end
            spnh_pkg::ST_TRACE_RD:
            begin
                node_raddr = hop_reg;
                state_next = spnh_pkg::ST_TRACE_CHK;
            end
            spnh_pkg::ST_TRACE_CHK:
            begin
                // Step back one predecessor until the next one is the source, is out of range or the step limit is hit
                if (rd_pred == src_reg || 32'(rd_pred) >= 32'(NODE_COUNT))
                begin
                    fin       = 1'b1;
                    fin_entry = {1'b0, 4'(hop_reg)};
                end
                else if (cnt_reg == CNT_W'(NODE_COUNT - 1))
                begin
                    fin       = 1'b1;
                    fin_entry = {1'b0, 4'(rd_pred)};
                end
                else
                begin
                    hop_next   = rd_pred;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = spnh_pkg::ST_TRACE_RD;
                end
            end
            default:
            begin
                state_next = spnh_pkg::ST_IDLE;
            end
        endcase

        // Store and report the finished route
        if (fin)
        begin
            tbl_we           = 1'b1;
            tbl_wdata        = fin_entry;
            done_next        = 1'b1;
            route_valid_next = !fin_entry[4];
            next_hop_next    = fin_entry[4] ? 4'd0 : fin_entry[3:0];
            state_next       = spnh_pkg::ST_IDLE;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= spnh_pkg::ST_CLEAR;
            clr_reg         <= '0;
            cnt_reg         <= '0;
            pv_reg          <= 1'b0;
            done_reg        <= 1'b0;
            own_address_reg <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= pv_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                own_address_reg <= cfg_wdata;
            end
        end
    end

    // Routing table, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < spnh_pkg::TABLE_DEPTH; i++)
            begin
                route_table_reg[i] <= spnh_pkg::ENTRY_W'(i);
            end
        end
        else if (tbl_we)
        begin
            route_table_reg[tbl_waddr] <= tbl_wdata;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pidx_reg        <= pidx_next;
        best_reg        <= best_next;
        found_reg       <= found_next;
        pick_reg        <= pick_next;
        cur_reg         <= cur_next;
        cur_cost_reg    <= cur_cost_next;
        row_base_reg    <= row_base_next;
        hop_reg         <= hop_next;
        tgt_reg         <= tgt_next;
        src_reg         <= src_next;
        route_valid_reg <= route_valid_next;
        next_hop_reg    <= next_hop_next;
    end

    `SPNH_ASSERT_IMP(a_bad_hop_zero, done_reg && !route_valid_reg, next_hop_reg == 4'd0, "invalid route with nonzero hop")
    `SPNH_ASSERT_NXT(a_write_silent, accept && op == spnh_pkg::OP_WRITE, !done_reg, "link write gave a result")
    `SPNH_ASSERT_NXT(a_done_after_work, !busy && !start, !done_reg, "result without a command")

endmodule

>>> rtl/spnh_ram.sv
module spnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
